@@ src/data_url_payload_decoder_top_macros.svh @@
// Assertion macros shared by the data URL payload decoder modules.
`ifndef DATA_URL_PAYLOAD_DECODER_TOP_MACROS_SVH
`define DATA_URL_PAYLOAD_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DUPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DUPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DUPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DUPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/dupd_pkg.sv @@
// Types, character constants and lookup functions of the data URL payload decoder.
package dupd_pkg;

  localparam int unsigned EntryBytes = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_UP_A    = 8'h41;
  localparam logic [7:0] CHAR_UP_F    = 8'h46;
  localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LO_A    = 8'h61;
  localparam logic [7:0] CHAR_LO_F    = 8'h66;
  localparam logic [7:0] CHAR_LO_Z    = 8'h7A;

  localparam logic [5:0] B64_PLUS  = 6'd62;
  localparam logic [5:0] B64_SLASH = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64_digit_t;

  // One queue entry: the bytes that one input beat releases from the window.
  typedef struct packed {
    logic [EntryBytes-1:0][7:0] bytes;
    logic [1:0]                 nbytes;
    logic                       last;
  } dupd_entry_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.val = 4'(c - CHAR_ZERO);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
      r.val = 4'(c - CHAR_LO_A + 8'd10);
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      r.val = 4'(c - CHAR_UP_A + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic b64_digit_t b64_value(input logic [7:0] c);
    b64_digit_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r.val = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      r.val = 6'(c - CHAR_LO_A + 8'd26);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.val = 6'(c - CHAR_ZERO + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.val = B64_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.val = B64_SLASH;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CHAR_TAB || c == CHAR_LF || c == CHAR_FF || c == CHAR_CR ||
           c == CHAR_SPACE;
  endfunction

endpackage

@@ src/dupd_if.sv @@
// Valid/ready channel interfaces for payload characters and decoded results.
interface dupd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface dupd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       status;
  logic       out_last;

  modport source (output valid, output out_byte, output has_byte, output status,
                  output out_last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input status,
                input out_last, output ready);
endinterface

@@ src/dupd_fifo.sv @@
// Two-entry queue that decouples the percent-decoding front from the base64 back.
module dupd_fifo
  import dupd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dupd_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output dupd_entry_t pop_data_o,
  output logic        empty_o
);
  `include "data_url_payload_decoder_top_macros.svh"

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  dupd_entry_t         mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = count_q == CntW'(QueueDepth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DUPD_ASSERT(a_fifo_bound, clk_i, rst_ni, count_q <= CntW'(QueueDepth), "queue overfilled")
  `DUPD_ASSERT_NEXT(a_fifo_drain, clk_i, rst_ni,
                    do_pop && !do_push && count_q == CntW'(1), empty_o,
                    "queue not empty after last pop")

endmodule

@@ src/dupd_front.sv @@
// Front end: accepts character beats and percent-decodes them in a three-character window.
module dupd_front
  import dupd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dupd_in_if.sink     in_ch,
  input  logic        full_i,
  output logic        push_o,
  output dupd_entry_t entry_o
);
  `include "data_url_payload_decoder_top_macros.svh"

  logic [1:0][7:0] win_q, win_d;
  logic [1:0]      win_count_q, win_count_d;
  logic            accept;
  hex_digit_t      hi, lo;
  logic            has_first;
  logic [7:0]      first;
  logic [7:0]      rem0, rem1;
  logic [1:0]      rcnt;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    hi        = hex_value(win_q[1]);
    lo        = hex_value(in_ch.in_char);
    has_first = 1'b0;
    first     = 8'd0;
    rem0      = 8'd0;
    rem1      = 8'd0;
    rcnt      = 2'd0;
    case (win_count_q)
      2'd2: begin
        has_first = 1'b1;
        if (win_q[0] == CHAR_PERCENT && hi.ok && lo.ok) begin
          first = {hi.val, lo.val};
        end else begin
          first = win_q[0];
          rem0  = win_q[1];
          rem1  = in_ch.in_char;
          rcnt  = 2'd2;
        end
      end
      2'd1: begin
        rem0 = win_q[0];
        rem1 = in_ch.in_char;
        rcnt = 2'd2;
      end
      default: begin
        rem0 = in_ch.in_char;
        rcnt = 2'd1;
      end
    endcase

    if (has_first) begin
      entry_o.bytes = {rem1, rem0, first};
    end else begin
      entry_o.bytes = {8'd0, rem1, rem0};
    end
    entry_o.last   = in_ch.in_last;
    entry_o.nbytes = in_ch.in_last ? ({1'b0, has_first} + rcnt) : {1'b0, has_first};
    push_o         = accept && (entry_o.nbytes != 2'd0 || in_ch.in_last);

    win_d       = win_q;
    win_count_d = win_count_q;
    if (accept) begin
      if (in_ch.in_last) begin
        win_d       = '0;
        win_count_d = 2'd0;
      end else begin
        win_d       = {rem1, rem0};
        win_count_d = rcnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      win_count_q <= 2'd0;
    end else begin
      win_q       <= win_d;
      win_count_q <= win_count_d;
    end
  end

  `DUPD_ASSERT(a_win_count, clk_i, rst_ni, win_count_q != 2'd3,
               "window holds more than two characters")
  `DUPD_ASSERT_NEXT(a_win_flush, clk_i, rst_ni, accept && in_ch.in_last,
                    win_count_q == 2'd0, "window not emptied at end of payload")

endmodule

@@ src/dupd_back.sv @@
// Back end: emits decoded bytes directly or through the forgiving base64 unpacker.
module dupd_back
  import dupd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  dupd_entry_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  dupd_out_if.source  out_ch
);
  `include "data_url_payload_decoder_top_macros.svh"

  logic [1:0]  idx_q, idx_d;
  logic [5:0]  store_q, store_d;
  logic [2:0]  bcount_q, bcount_d;
  logic        saw_q, saw_d;
  logic [1:0]  pad_q, pad_d;
  logic [1:0]  digit_q, digit_d;
  logic        err_q, err_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        has_byte_q, status_q, out_last_q;

  logic        step, do_byte;
  logic [7:0]  v;
  b64_digit_t  dig;
  logic [11:0] acc, masked;
  logic [3:0]  bsum;
  logic [2:0]  bnew;
  logic [1:0]  total;
  logic        err_close;
  logic        load;
  logic [7:0]  ld_byte;
  logic        ld_has, ld_st, ld_last;

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.has_byte = has_byte_q;
  assign out_ch.status   = status_q;
  assign out_ch.out_last = out_last_q;

  assign step    = !empty_i && (!out_valid_q || out_ch.ready);
  assign do_byte = idx_q < head_i.nbytes;

  always_comb begin
    v         = head_i.bytes[idx_q];
    dig       = b64_value(v);
    acc       = {store_q, dig.val};
    bsum      = {1'b0, bcount_q} + 4'd6;
    bnew      = 3'(bsum - 4'd8);
    masked    = acc & ((12'd1 << bnew) - 12'd1);
    total     = digit_q + pad_q;
    err_close = err_q || (pad_q != 2'd0 && (total != 2'd0 || pad_q == 2'd3)) ||
                digit_q == 2'd1;

    idx_d    = idx_q;
    store_d  = store_q;
    bcount_d = bcount_q;
    saw_d    = saw_q;
    pad_d    = pad_q;
    digit_d  = digit_q;
    err_d    = err_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    ld_byte  = 8'd0;
    ld_has   = 1'b0;
    ld_st    = 1'b0;
    ld_last  = 1'b0;

    if (step) begin
      if (do_byte) begin
        idx_d = idx_q + 2'd1;
        if (!mode_i) begin
          load    = 1'b1;
          ld_byte = v;
          ld_has  = 1'b1;
        end else if (!err_q && !is_space(v)) begin
          if (v == CHAR_EQUALS) begin
            saw_d = 1'b1;
            if (pad_q != 2'd3) begin
              pad_d = pad_q + 2'd1;
            end
          end else if (saw_q || !dig.ok) begin
            err_d = 1'b1;
          end else begin
            digit_d = digit_q + 2'd1;
            if (bsum >= 4'd8) begin
              load     = 1'b1;
              ld_byte  = 8'(acc >> bnew);
              ld_has   = 1'b1;
              bcount_d = bnew;
              store_d  = masked[5:0];
            end else begin
              bcount_d = bsum[2:0];
              store_d  = acc[5:0];
            end
          end
        end
        if (!head_i.last && idx_q + 2'd1 == head_i.nbytes) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end
      end else if (head_i.last) begin
        load     = 1'b1;
        ld_st    = mode_i && err_close;
        ld_last  = 1'b1;
        pop_o    = 1'b1;
        idx_d    = 2'd0;
        store_d  = 6'd0;
        bcount_d = 3'd0;
        saw_d    = 1'b0;
        pad_d    = 2'd0;
        digit_d  = 2'd0;
        err_d    = 1'b0;
      end else begin
        pop_o = 1'b1;
        idx_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      store_q     <= 6'd0;
      bcount_q    <= 3'd0;
      saw_q       <= 1'b0;
      pad_q       <= 2'd0;
      digit_q     <= 2'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      store_q  <= store_d;
      bcount_q <= bcount_d;
      saw_q    <= saw_d;
      pad_q    <= pad_d;
      digit_q  <= digit_d;
      err_q    <= err_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= ld_byte;
      has_byte_q <= ld_has;
      status_q   <= ld_st;
      out_last_q <= ld_last;
    end
  end

  `DUPD_ASSERT(a_bcount_even, clk_i, rst_ni, !bcount_q[0], "odd base64 bit count")
  `DUPD_ASSERT_NEXT(a_close_clears, clk_i, rst_ni, step && !do_byte && head_i.last,
                    bcount_q == 3'd0 && !err_q && pad_q == 2'd0 && idx_q == 2'd0,
                    "payload state not cleared after closing beat")

endmodule

@@ src/data_url_payload_decoder_top.sv @@
// Top level of the data URL payload decoder: mode register, front end, queue and back end.
//
//   Channel  Dir  Beat contents
//   in_ch    in   in_char, in_last
//   out_ch   out  out_byte, has_byte, status, out_last
//   cfg      in   cfg_we_i, cfg_wdata_i (base64 mode)
//
// While the queue has room, the front end takes one character beat per cycle and
// releases at most one byte, or up to three plus the closing beat at the end of a
// payload. The back end handles one released byte or the closing beat per cycle
// while out_ch is ready, so a steady stream runs at one character per cycle.
// A two-entry queue lets the front keep accepting while the output waits.
// Reset is asynchronous and active low and clears all payload state and the mode.
module data_url_payload_decoder_top
  import dupd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dupd_in_if.sink     in_ch,
  dupd_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic        mode_q;
  logic        push, full, pop, empty;
  dupd_entry_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  dupd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_data)
  );

  dupd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  dupd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
